### hdl/serial_frame_parser_with_ack_assert.svh
// Assertion macros shared by the frame parser RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef SERIAL_FRAME_PARSER_WITH_ACK_ASSERT_SVH
`define SERIAL_FRAME_PARSER_WITH_ACK_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define SFPA_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error("sfpa check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define SFPA_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error("sfpa check failed");

`endif

### hdl/sfpa_pkg.sv
// Package for the serial frame parser: byte codes, frame record type,
// parser phase encoding and the CRC-8 step. No dependencies.
package sfpa_pkg;

  // Byte codes
  localparam logic [7:0] START_ACK = 8'hA0;  // start byte that requests an ack
  localparam logic [7:0] ACK_HEAD  = 8'hA1;  // first byte of the ack
  localparam logic [7:0] LIMIT_LO  = 8'hE0;  // limit-switch source range
  localparam logic [7:0] LIMIT_HI  = 8'hE4;
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONE  = 8'h01;
  localparam logic [7:0] CRC_POLY  = 8'h8C;  // reflected CRC-8 polynomial

  // Frame queue depth default
  localparam int FIFO_DEPTH = 2;

  // Output sequence steps of one frame
  localparam logic [2:0] STEP_HEAD    = 3'd0;
  localparam logic [2:0] STEP_SRC     = 3'd1;
  localparam logic [2:0] STEP_PAD0    = 3'd2;
  localparam logic [2:0] STEP_PAD1    = 3'd3;
  localparam logic [2:0] STEP_CRC     = 3'd4;
  localparam logic [2:0] STEP_SUMMARY = 3'd5;

  // Parser phases, one-hot
  typedef enum logic [5:0] {
    PH_START   = 6'b000001,
    PH_DEST    = 6'b000010,
    PH_SOURCE  = 6'b000100,
    PH_LENGTH  = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_CRC     = 6'b100000
  } phase_e;

  // One finished frame, as passed from parser to emitter
  typedef struct packed {
    logic [7:0] start_code;
    logic [7:0] source_addr;
    logic [7:0] payload_len;
    logic [7:0] first_payload;
    logic [7:0] received_crc;
    logic [7:0] limit_position;
    logic [7:0] ack_crc;
  } frame_t;

  // One byte of the reflected CRC-8, LSB first
  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### hdl/serial_frame_parser_with_ack.sv
// Top level of the serial frame parser with acknowledge.
// Depends on sfpa_pkg, sfpa_front, sfpa_queue and sfpa_back.
//
//   channel | dir | handshake                | payload
//   --------+-----+--------------------------+-------------------------------
//   rx      | in  | rx_valid_i / rx_stall_o  | rx_byte_i
//   tx      | out | out_valid_o / out_stall_i| is_ack_o .. last_o (9 fields)
//
// Parser takes one byte per cycle unless stalled; records queue at their CRC byte.
// Emitter sends one item per cycle unless stalled: six for 0xA0, else a summary.
// rx_stall_o rises only on a CRC byte while the frame queue (FifoDepth) is full.
// Output is registered; out_stall_i holds the item and backs up into the queue.
// rst_ni clears parser phase, held fields, queue pointers and output valid at once.
module serial_frame_parser_with_ack #(
  parameter int FifoDepth = sfpa_pkg::FIFO_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] rx_byte_i,
  input  logic       rx_valid_i,
  output logic       rx_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       is_ack_o,
  output logic [7:0] tx_byte_o,
  output logic [7:0] start_code_o,
  output logic [7:0] source_addr_o,
  output logic [7:0] payload_len_o,
  output logic [7:0] first_payload_o,
  output logic [7:0] received_crc_o,
  output logic [7:0] limit_position_o,
  output logic       last_o
);

  sfpa_pkg::frame_t rec, head;
  logic push, pop, empty, full;

  sfpa_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_byte_i  (rx_byte_i),
    .rx_valid_i (rx_valid_i),
    .rx_stall_o (rx_stall_o),
    .q_full_i   (full),
    .push_o     (push),
    .rec_o      (rec)
  );

  sfpa_queue #(
    .Depth (FifoDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (rec),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  sfpa_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .empty_i          (empty),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .is_ack_o         (is_ack_o),
    .tx_byte_o        (tx_byte_o),
    .start_code_o     (start_code_o),
    .source_addr_o    (source_addr_o),
    .payload_len_o    (payload_len_o),
    .first_payload_o  (first_payload_o),
    .received_crc_o   (received_crc_o),
    .limit_position_o (limit_position_o),
    .last_o           (last_o)
  );

endmodule

### hdl/sfpa_front.sv
// Parser front end: walks the frame phases one byte per cycle unless stalled,
// and builds a frame record at the CRC byte. Depends on sfpa_pkg.
module sfpa_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          rx_byte_i,
  input  logic                rx_valid_i,
  output logic                rx_stall_o,
  input  logic                q_full_i,
  output logic                push_o,
  output sfpa_pkg::frame_t    rec_o
);

  sfpa_pkg::phase_e phase_q, phase_d;
  logic [7:0] start_q, start_d;
  logic [7:0] source_q, source_d;
  logic [7:0] len_q, len_d;
  logic [7:0] left_q, left_d;
  logic [7:0] first_q, first_d;
  logic [7:0] limit_q, limit_d;
  logic [7:0] crc_q, crc_d;
  logic       accept;
  logic       src_is_limit;

  // Only the CRC byte needs room in the queue
  assign rx_stall_o   = (phase_q == sfpa_pkg::PH_CRC) && q_full_i;
  assign accept       = rx_valid_i && !rx_stall_o;
  assign src_is_limit = (source_q >= sfpa_pkg::LIMIT_LO) && (source_q <= sfpa_pkg::LIMIT_HI);

  // Phase sequencing and field capture
  always_comb begin
    phase_d  = phase_q;
    start_d  = start_q;
    source_d = source_q;
    len_d    = len_q;
    left_d   = left_q;
    first_d  = first_q;
    limit_d  = limit_q;
    crc_d    = crc_q;
    if (accept) begin
      case (phase_q)
        sfpa_pkg::PH_START: begin
          if (!(rx_byte_i inside {sfpa_pkg::BYTE_ZERO, sfpa_pkg::BYTE_ONE})) begin
            start_d = rx_byte_i;
            phase_d = sfpa_pkg::PH_DEST;
          end
        end
        sfpa_pkg::PH_DEST: begin
          if (rx_byte_i == sfpa_pkg::BYTE_ZERO) begin
            phase_d = sfpa_pkg::PH_SOURCE;
          end
        end
        sfpa_pkg::PH_SOURCE: begin
          source_d = rx_byte_i;
          // ack CRC runs over {0, source, 0}; the leading zero leaves it at 0
          crc_d    = sfpa_pkg::crc8_step(sfpa_pkg::BYTE_ZERO, rx_byte_i);
          phase_d  = sfpa_pkg::PH_LENGTH;
        end
        sfpa_pkg::PH_LENGTH: begin
          len_d   = rx_byte_i;
          left_d  = rx_byte_i;
          first_d = sfpa_pkg::BYTE_ZERO;
          crc_d   = sfpa_pkg::crc8_step(crc_q, sfpa_pkg::BYTE_ZERO);
          phase_d = (rx_byte_i == sfpa_pkg::BYTE_ZERO) ? sfpa_pkg::PH_CRC
                                                       : sfpa_pkg::PH_PAYLOAD;
        end
        sfpa_pkg::PH_PAYLOAD: begin
          if (left_q == len_q) begin
            first_d = rx_byte_i;
          end
          left_d = left_q - 8'd1;
          if (left_q == 8'd1) begin
            phase_d = sfpa_pkg::PH_CRC;
          end
        end
        sfpa_pkg::PH_CRC: begin
          if (src_is_limit) begin
            limit_d = source_q;
          end
          phase_d = sfpa_pkg::PH_START;
        end
        default: begin
          phase_d = sfpa_pkg::PH_START;
        end
      endcase
    end
  end

  // Frame record goes out with the CRC byte
  assign push_o              = accept && (phase_q == sfpa_pkg::PH_CRC);
  assign rec_o.start_code    = start_q;
  assign rec_o.source_addr   = source_q;
  assign rec_o.payload_len   = len_q;
  assign rec_o.first_payload = first_q;
  assign rec_o.received_crc  = rx_byte_i;
  assign rec_o.limit_position = src_is_limit ? source_q : limit_q;
  assign rec_o.ack_crc       = crc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= sfpa_pkg::PH_START;
      start_q  <= '0;
      source_q <= '0;
      len_q    <= '0;
      left_q   <= '0;
      first_q  <= '0;
      limit_q  <= '0;
      crc_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      start_q  <= start_d;
      source_q <= source_d;
      len_q    <= len_d;
      left_q   <= left_d;
      first_q  <= first_d;
      limit_q  <= limit_d;
      crc_q    <= crc_d;
    end
  end

endmodule

### hdl/sfpa_queue.sv
// Small register FIFO of frame records between parser and emitter.
// Depends on sfpa_pkg and the assertion macro header.
`include "serial_frame_parser_with_ack_assert.svh"

module sfpa_queue #(
  parameter int Depth = sfpa_pkg::FIFO_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sfpa_pkg::frame_t rec_i,
  input  logic             pop_i,
  output sfpa_pkg::frame_t head_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  sfpa_pkg::frame_t      mem_q [Depth];
  logic [PtrW-1:0]       wr_q, wr_d;
  logic [PtrW-1:0]       rd_q, rd_d;
  logic [CntW-1:0]       cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign head_o  = mem_q[rd_q];

  // Pointer wrap and occupancy
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  `SFPA_ASSERT_NOW(a_no_push_full, push_i, !full_o)
  `SFPA_ASSERT_NOW(a_no_pop_empty, pop_i, !empty_o)
  `SFPA_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CntW'(Depth))

endmodule

### hdl/sfpa_back.sv
// Emitter back end: expands each frame record into the ack bytes (when
// requested) and summary item, one per cycle unless stalled, into an
// output register. Depends on sfpa_pkg and the assertion macro header.
`include "serial_frame_parser_with_ack_assert.svh"

module sfpa_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sfpa_pkg::frame_t head_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             is_ack_o,
  output logic [7:0]       tx_byte_o,
  output logic [7:0]       start_code_o,
  output logic [7:0]       source_addr_o,
  output logic [7:0]       payload_len_o,
  output logic [7:0]       first_payload_o,
  output logic [7:0]       received_crc_o,
  output logic [7:0]       limit_position_o,
  output logic             last_o
);

  sfpa_pkg::frame_t cur_q, cur_d, src;
  logic [2:0] step_q, step_d, step;
  logic       active_q, active_d;
  logic       valid_q, valid_d;
  logic       have, load;
  logic       is_ack_q, is_ack_d, last_q, last_d;
  logic [7:0] tx_q, tx_d, start_q, start_d, source_q, source_d, len_q, len_d;
  logic [7:0] first_q, first_d, crc_q, crc_d, limit_q, limit_d;

  // Current record: held one, or the queue head for a fresh frame
  assign have = active_q || !empty_i;
  assign src  = active_q ? cur_q : head_i;
  assign step = active_q ? step_q
              : ((head_i.start_code == sfpa_pkg::START_ACK) ? sfpa_pkg::STEP_HEAD
                                                            : sfpa_pkg::STEP_SUMMARY);
  assign load  = (!valid_q || !out_stall_i) && have;
  assign pop_o = load && !active_q;

  // Next item and sequence state
  always_comb begin
    cur_d    = cur_q;
    step_d   = step_q;
    active_d = active_q;
    valid_d  = valid_q && out_stall_i;
    is_ack_d = is_ack_q;
    tx_d     = tx_q;
    start_d  = start_q;
    source_d = source_q;
    len_d    = len_q;
    first_d  = first_q;
    crc_d    = crc_q;
    limit_d  = limit_q;
    last_d   = last_q;
    if (load) begin
      valid_d  = 1'b1;
      cur_d    = src;
      is_ack_d = (step != sfpa_pkg::STEP_SUMMARY);
      last_d   = (step == sfpa_pkg::STEP_SUMMARY);
      start_d  = '0;
      source_d = '0;
      len_d    = '0;
      first_d  = '0;
      crc_d    = '0;
      limit_d  = '0;
      case (step)
        sfpa_pkg::STEP_HEAD: tx_d = sfpa_pkg::ACK_HEAD;
        sfpa_pkg::STEP_SRC:  tx_d = src.source_addr;
        sfpa_pkg::STEP_PAD0: tx_d = sfpa_pkg::BYTE_ZERO;
        sfpa_pkg::STEP_PAD1: tx_d = sfpa_pkg::BYTE_ZERO;
        sfpa_pkg::STEP_CRC:  tx_d = src.ack_crc;
        default: begin
          tx_d     = sfpa_pkg::BYTE_ZERO;
          start_d  = src.start_code;
          source_d = src.source_addr;
          len_d    = src.payload_len;
          first_d  = src.first_payload;
          crc_d    = src.received_crc;
          limit_d  = src.limit_position;
        end
      endcase
      if (step == sfpa_pkg::STEP_SUMMARY) begin
        active_d = 1'b0;
      end else begin
        active_d = 1'b1;
        step_d   = step + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      valid_q  <= 1'b0;
      step_q   <= sfpa_pkg::STEP_HEAD;
    end else begin
      active_q <= active_d;
      valid_q  <= valid_d;
      step_q   <= step_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    is_ack_q <= is_ack_d;
    last_q   <= last_d;
    tx_q     <= tx_d;
    start_q  <= start_d;
    source_q <= source_d;
    len_q    <= len_d;
    first_q  <= first_d;
    crc_q    <= crc_d;
    limit_q  <= limit_d;
  end

  assign out_valid_o      = valid_q;
  assign is_ack_o         = is_ack_q;
  assign tx_byte_o        = tx_q;
  assign start_code_o     = start_q;
  assign source_addr_o    = source_q;
  assign payload_len_o    = len_q;
  assign first_payload_o  = first_q;
  assign received_crc_o   = crc_q;
  assign limit_position_o = limit_q;
  assign last_o           = last_q;

  `SFPA_ASSERT_NOW(a_ack_not_last, valid_q && is_ack_q, !last_q)
  `SFPA_ASSERT_NEXT(a_summary_ends_run, load && (step == sfpa_pkg::STEP_SUMMARY),
                    !active_q && last_q)

endmodule
